/* rtl/voxel_label_boundary_detect_core_macros.svh */
// Assertion macros used by the boundary detector job queue.
`ifndef VOXEL_LABEL_BOUNDARY_DETECT_CORE_MACROS_SVH
`define VOXEL_LABEL_BOUNDARY_DETECT_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VLBD_ASSERT_IMP(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define VLBD_ASSERT_NXT(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

/* rtl/vlbd_pkg.sv */
// Shared constants of the voxel label boundary detector.
`default_nettype none
package vlbd_pkg;
  localparam int LABEL_W    = 8;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W_W    = 7;
  localparam int CFG_H_W    = 7;
  localparam int CFG_D_W    = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEPTH  = 2'd2;

  localparam logic [1:0] SLOT_LAST = 2'd2;
endpackage
`default_nettype wire

/* rtl/vlbd_stream_if.sv */
// Stream interfaces: voxel input channel and boundary result channel.
`default_nettype none
interface vlbd_in_if import vlbd_pkg::*;;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [LABEL_W-1:0] voxel_label;
  modport source (output valid, mode, voxel_label, input ready);
  modport sink   (input valid, mode, voxel_label, output ready);
endinterface

interface vlbd_out_if;
  logic valid;
  logic ready;
  logic is_boundary;
  logic last_voxel;
  modport source (output valid, is_boundary, last_voxel, input ready);
  modport sink   (input valid, is_boundary, last_voxel, output ready);
endinterface
`default_nettype wire

/* rtl/vlbd_job_fifo.sv */
// Small job queue between the front and the back end.
`default_nettype none
`include "voxel_label_boundary_detect_core_macros.svh"
module vlbd_job_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `VLBD_ASSERT_IMP(a_no_overflow, clk, rst, push, !full || pop, "job queue overflow")
  `VLBD_ASSERT_IMP(a_no_underflow, clk, rst, pop, !empty, "job queue underflow")
  `VLBD_ASSERT_NXT(a_push_fills, clk, rst, push && !pop, !empty, "job lost after push")
endmodule
`default_nettype wire

/* rtl/vlbd_front.sv */
// Front end: takes voxel transactions, writes slice buffers, issues result jobs.
`default_nettype none
module vlbd_front import vlbd_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_DEPTH  = 1024,
  parameter int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  parameter int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  parameter int ZW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1,
  parameter int XN = $clog2(MAX_WIDTH + 1),
  parameter int YN = $clog2(MAX_HEIGHT + 1),
  parameter int ZN = $clog2(MAX_DEPTH + 1),
  parameter int AW = $clog2(3 * MAX_WIDTH * MAX_HEIGHT),
  parameter int JW = 3 + XW + YW + ZW
) (
  input  wire logic          clk,
  input  wire logic          rst,
  vlbd_in_if.sink            in_ch,
  input  wire logic [XN-1:0] w,
  input  wire logic [YN-1:0] h,
  input  wire logic [ZN-1:0] d,
  input  wire logic          q_full,
  input  wire logic          pend_valid,
  input  wire logic [ZW-1:0] pend_z,
  output logic               push,
  output logic [JW-1:0]      job,
  output logic               we,
  output logic [AW-1:0]      waddr,
  output logic [LABEL_W-1:0] wdata
);
  logic [XW-1:0] in_x, in_x_next, out_x, out_x_next;
  logic [YW-1:0] in_y, in_y_next, out_y, out_y_next;
  logic [ZW-1:0] in_z, in_z_next, out_z, out_z_next;
  logic [1:0]    in_slot, in_slot_next, out_slot, out_slot_next;
  logic          done, done_next, flush, flush_next;
  logic          acc, hazard, lst;

  // a write into slice z+2 reuses the slot of slice z-1
  assign hazard = pend_valid && (int'(pend_z) + 2 == int'(in_z));
  assign in_ch.ready = !q_full && !flush && !hazard;
  assign acc = in_ch.valid && in_ch.ready;

  assign we    = acc && !in_ch.mode && !done;
  assign waddr = AW'(int'(in_slot) * MAX_WIDTH * MAX_HEIGHT + int'(in_y) * MAX_WIDTH
                     + int'(in_x));
  assign wdata = in_ch.voxel_label;
  assign job   = {lst, out_slot, out_z, out_y, out_x};

  always_comb begin
    int ix, iy, iz, ox, oy, oz, fx, fy, fz, wi, hi, di;
    logic [1:0] isl, osl;
    logic dn, fin_in, aft, fl;
    wi = int'(w);
    hi = int'(h);
    di = int'(d);
    ix = int'(in_x);
    iy = int'(in_y);
    iz = int'(in_z);
    ox = int'(out_x);
    oy = int'(out_y);
    oz = int'(out_z);
    isl = in_slot;
    osl = out_slot;
    dn = done;
    fl = flush && pend_valid;
    fin_in = (ix + 1 >= wi) && (iy + 1 >= hi) && (iz + 1 >= di);
    if (we) begin
      if (fin_in) begin
        dn = 1'b1;
      end else if (ix + 1 < wi) begin
        ix = ix + 1;
      end else begin
        ix = 0;
        if (iy + 1 < hi) begin
          iy = iy + 1;
        end else begin
          iy = 0;
          iz = iz + 1;
          isl = (isl == SLOT_LAST) ? 2'd0 : isl + 2'd1;
        end
      end
    end
    fx = (ox + 1 < wi) ? ox + 1 : ox;
    fy = (oy + 1 < hi) ? oy + 1 : oy;
    fz = (oz + 1 < di) ? oz + 1 : oz;
    if (iz != fz) begin
      aft = iz > fz;
    end else if (iy != fy) begin
      aft = iy > fy;
    end else begin
      aft = ix > fx;
    end
    lst  = (ox + 1 >= wi) && (oy + 1 >= hi) && (oz + 1 >= di);
    push = acc && (dn || aft);
    if (push) begin
      if (lst) begin
        ix = 0; iy = 0; iz = 0; isl = 2'd0;
        ox = 0; oy = 0; oz = 0; osl = 2'd0;
        dn = 1'b0;
        fl = 1'b1;
      end else if (ox + 1 < wi) begin
        ox = ox + 1;
      end else begin
        ox = 0;
        if (oy + 1 < hi) begin
          oy = oy + 1;
        end else begin
          oy = 0;
          oz = oz + 1;
          osl = (osl == SLOT_LAST) ? 2'd0 : osl + 2'd1;
        end
      end
    end
    in_x_next     = XW'(ix);
    in_y_next     = YW'(iy);
    in_z_next     = ZW'(iz);
    in_slot_next  = isl;
    out_x_next    = XW'(ox);
    out_y_next    = YW'(oy);
    out_z_next    = ZW'(oz);
    out_slot_next = osl;
    done_next     = dn;
    flush_next    = fl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_x <= '0; in_y <= '0; in_z <= '0; in_slot <= '0;
      out_x <= '0; out_y <= '0; out_z <= '0; out_slot <= '0;
      done <= 1'b0;
      flush <= 1'b0;
    end else begin
      in_x <= in_x_next; in_y <= in_y_next; in_z <= in_z_next; in_slot <= in_slot_next;
      out_x <= out_x_next; out_y <= out_y_next; out_z <= out_z_next;
      out_slot <= out_slot_next;
      done <= done_next;
      flush <= flush_next;
    end
  end
endmodule
`default_nettype wire

/* rtl/vlbd_back.sv */
// Back end: slice buffer memory and the serial 26-neighbour scan per job.
`default_nettype none
module vlbd_back import vlbd_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_DEPTH  = 1024,
  parameter int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  parameter int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  parameter int ZW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1,
  parameter int XN = $clog2(MAX_WIDTH + 1),
  parameter int YN = $clog2(MAX_HEIGHT + 1),
  parameter int ZN = $clog2(MAX_DEPTH + 1),
  parameter int AW = $clog2(3 * MAX_WIDTH * MAX_HEIGHT),
  parameter int JW = 3 + XW + YW + ZW
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [XN-1:0]      w,
  input  wire logic [YN-1:0]      h,
  input  wire logic [ZN-1:0]      d,
  input  wire logic               we,
  input  wire logic [AW-1:0]      waddr,
  input  wire logic [LABEL_W-1:0] wdata,
  input  wire logic               q_empty,
  input  wire logic [JW-1:0]      q_job,
  output logic                    q_pop,
  output logic                    busy,
  output logic [ZW-1:0]           cur_z,
  vlbd_out_if.source              out_ch
);
  localparam int DEPTH = 3 * MAX_WIDTH * MAX_HEIGHT;

  typedef enum logic [2:0] {B_IDLE, B_SELF, B_SCAN, B_TAIL, B_DONE} bstate_t;

  logic [LABEL_W-1:0] mem [DEPTH];
  logic [LABEL_W-1:0] rdata, self_lbl;
  logic [AW-1:0]      raddr;
  bstate_t            state;
  logic [XW-1:0]      jx;
  logic [YW-1:0]      jy;
  logic [ZW-1:0]      jz;
  logic [1:0]         jslot, dx, dy, dz;
  logic               jlast, bnd, t_valid, t_self, t_use, use_n;
  logic               o_valid, o_bnd, o_last;

  assign q_pop  = (state == B_IDLE) && !q_empty;
  assign busy   = (state != B_IDLE);
  assign cur_z  = jz;
  assign out_ch.valid       = o_valid;
  assign out_ch.is_boundary = o_bnd;
  assign out_ch.last_voxel  = o_last;

  always_comb begin
    int nx, ny, nz;
    logic [1:0] ns;
    nx = int'(jx) + int'(dx) - 1;
    ny = int'(jy) + int'(dy) - 1;
    nz = int'(jz) + int'(dz) - 1;
    unique case (dz)
      2'd0:    ns = (jslot == 2'd0) ? SLOT_LAST : jslot - 2'd1;
      2'd2:    ns = (jslot == SLOT_LAST) ? 2'd0 : jslot + 2'd1;
      default: ns = jslot;
    endcase
    use_n = (nx >= 0) && (nx < int'(w)) && (ny >= 0) && (ny < int'(h))
            && (nz >= 0) && (nz < int'(d)) && !(dx == 2'd1 && dy == 2'd1 && dz == 2'd1);
    if (state == B_SELF) begin
      raddr = AW'(int'(jslot) * MAX_WIDTH * MAX_HEIGHT + int'(jy) * MAX_WIDTH + int'(jx));
    end else begin
      raddr = AW'(int'(ns) * MAX_WIDTH * MAX_HEIGHT + ny * MAX_WIDTH + nx);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      t_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      t_valid <= (state == B_SELF) || (state == B_SCAN);
      if (state == B_DONE && (!o_valid || out_ch.ready)) begin
        o_valid <= 1'b1;
      end else if (o_valid && out_ch.ready) begin
        o_valid <= 1'b0;
      end
      if (t_valid) begin
        if (t_self) begin
          self_lbl <= rdata;
        end else if (t_use && rdata != self_lbl) begin
          bnd <= 1'b1;
        end
      end
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            {jlast, jslot, jz, jy, jx} <= q_job;
            bnd   <= 1'b0;
            state <= B_SELF;
          end
        end
        B_SELF: begin
          t_self  <= 1'b1;
          dx <= 2'd0; dy <= 2'd0; dz <= 2'd0;
          state <= B_SCAN;
        end
        B_SCAN: begin
          t_self  <= 1'b0;
          t_use   <= use_n;
          if (dx != 2'd2) begin
            dx <= dx + 2'd1;
          end else begin
            dx <= 2'd0;
            if (dy != 2'd2) begin
              dy <= dy + 2'd1;
            end else begin
              dy <= 2'd0;
              dz <= dz + 2'd1;
              if (dz == 2'd2) begin
                state <= B_TAIL;
              end
            end
          end
        end
        B_TAIL: state <= B_DONE;
        B_DONE: begin
          if (!o_valid || out_ch.ready) begin
            o_bnd   <= bnd;
            o_last  <= jlast;
            state   <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/voxel_label_boundary_detect_core.sv */
// Top level of the streaming 3D label boundary detector.
// Usage:
//  - in_ch carries voxel transactions in raster order (x fastest, then y, then z):
//    mode 0 with a label, mode 1 as a drain. After the last voxel, send drains
//    until the result with last_voxel set appears; extra drains give nothing.
//  - out_ch gives one is_boundary flag per voxel, in raster order.
//  - Config (cfg_we/cfg_index/cfg_data) sets width, height (7 bits each), depth;
//    write it only while the block is idle. 0 acts as 1, large values clamp.
// Timing:
//  - The front end takes one transaction per cycle unless held off, and issues
//    jobs into a 4-entry job queue. Each result is computed by the back end by
//    a serial scan of the slice buffer memory, one read per cycle (queue pop,
//    self read, scan of the neighbour slots, tail, output load); it takes a new
//    job only after the previous result is loaded. The front holds off while the
//    queue is full, while a write would reuse the slot of a slice that a pending
//    job still reads, and after the last voxel until all volume jobs are done.
//  - A result's job is queued as its far neighbour's transaction is taken.
// Reset: synchronous; positions clear, buffers are not cleared (every entry is
// written before it is read). A stalled receiver holds the output register,
// which backs up the back end, the queue and then in_ch.ready.
`default_nettype none
module voxel_label_boundary_detect_core import vlbd_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_DEPTH  = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  vlbd_in_if.sink                    in_ch,
  vlbd_out_if.source                 out_ch
);
  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int ZW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int XN = $clog2(MAX_WIDTH + 1);
  localparam int YN = $clog2(MAX_HEIGHT + 1);
  localparam int ZN = $clog2(MAX_DEPTH + 1);
  localparam int AW = $clog2(3 * MAX_WIDTH * MAX_HEIGHT);
  localparam int JW = 3 + XW + YW + ZW;

  logic [CFG_W_W-1:0] volume_width;
  logic [CFG_H_W-1:0] volume_height;
  logic [CFG_D_W-1:0] volume_depth;
  logic [XN-1:0]      w;
  logic [YN-1:0]      h;
  logic [ZN-1:0]      d;

  logic               push, q_full, q_empty, q_pop, busy, we;
  logic [JW-1:0]      job, q_job;
  logic [ZW-1:0]      cur_z;
  logic [AW-1:0]      waddr;
  logic [LABEL_W-1:0] wdata;
  logic               pend_valid;
  logic [ZW-1:0]      pend_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_width  <= CFG_W_W'(64);
      volume_height <= CFG_H_W'(64);
      volume_depth  <= CFG_D_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH:  volume_width  <= cfg_data[CFG_W_W-1:0];
        CFG_IDX_HEIGHT: volume_height <= cfg_data[CFG_H_W-1:0];
        CFG_IDX_DEPTH:  volume_depth  <= cfg_data[CFG_D_W-1:0];
        default: ;
      endcase
    end
  end

  // sizes in use: 0 acts as 1, clamp to the built maximum
  assign w = (volume_width == '0) ? XN'(1) :
             (int'(volume_width) > MAX_WIDTH) ? XN'(MAX_WIDTH) : XN'(volume_width);
  assign h = (volume_height == '0) ? YN'(1) :
             (int'(volume_height) > MAX_HEIGHT) ? YN'(MAX_HEIGHT) : YN'(volume_height);
  assign d = (volume_depth == '0) ? ZN'(1) :
             (int'(volume_depth) > MAX_DEPTH) ? ZN'(MAX_DEPTH) : ZN'(volume_depth);

  // oldest job not yet finished: the one in the back end, else the queue head
  assign pend_valid = busy || !q_empty;
  assign pend_z     = busy ? cur_z : q_job[XW+YW +: ZW];

  vlbd_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_DEPTH(MAX_DEPTH)
  ) u_front (
    .clk, .rst, .in_ch, .w, .h, .d, .q_full, .pend_valid, .pend_z,
    .push, .job, .we, .waddr, .wdata
  );

  vlbd_job_fifo #(.WIDTH(JW), .DEPTH(4)) u_fifo (
    .clk, .rst, .push, .din(job), .full(q_full), .pop(q_pop), .dout(q_job),
    .empty(q_empty)
  );

  vlbd_back #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_DEPTH(MAX_DEPTH)
  ) u_back (
    .clk, .rst, .w, .h, .d, .we, .waddr, .wdata, .q_empty, .q_job, .q_pop,
    .busy, .cur_z, .out_ch
  );
endmodule
`default_nettype wire
